// ===== rtl/mfsc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsc_pkg
// shared sizes, codes and item types of the strided convolution core
// ----------------------------------------------------------------------------
package mfsc_pkg;

  localparam int MAX_FILTERS  = 8;
  localparam int MAX_KERNEL   = 8;
  localparam int MAX_WIDTH    = 256;
  localparam int MAX_CHANNELS = 4;

  localparam int FILT_W = $clog2(MAX_FILTERS);
  localparam int KER_W  = $clog2(MAX_KERNEL);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int CH_W   = $clog2(MAX_CHANNELS);

  localparam int LINE_DEPTH = MAX_KERNEL * MAX_WIDTH * MAX_CHANNELS;
  localparam int LINE_AW    = KER_W + COL_W + CH_W;
  localparam int WGT_DEPTH  = MAX_FILTERS * MAX_KERNEL * MAX_KERNEL * MAX_CHANNELS;
  localparam int WGT_AW     = FILT_W + 2 * KER_W + CH_W;

  localparam int DATA_W = 16;
  localparam int PROD_W = 33;
  localparam int SUM_W  = 40;

  typedef enum logic {
    OP_PIXEL  = 1'b0,
    OP_WEIGHT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    REG_IMAGE_WIDTH   = 3'd0,
    REG_IMAGE_HEIGHT  = 3'd1,
    REG_KERNEL_SIZE   = 3'd2,
    REG_STEP_SIZE     = 3'd3,
    REG_FILTER_COUNT  = 3'd4,
    REG_CHANNEL_COUNT = 3'd5
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic                     opcode;
    logic [15:0]              pixel_value;
    logic signed [15:0]       weight_value;
    logic [2:0]               weight_filter;
    logic [2:0]               weight_row;
    logic [2:0]               weight_col;
    logic [1:0]               weight_channel;
  } in_item_t;

  typedef struct packed {
    logic [7:0]               out_row;
    logic [7:0]               out_col;
    logic [2:0]               filter_index;
    logic signed [SUM_W-1:0]  dot_sum;
    logic                     last_of_pixel;
  } out_item_t;

  typedef struct packed {
    logic [2:0] index;
    logic [8:0] value;
  } cfg_item_t;

  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } mac_ctrl_t;

  // zero acts as one, above the limit acts as the limit
  function automatic logic [8:0] clamp9(logic [8:0] v, logic [8:0] hi);
    logic [8:0] r;
    if (v == 9'd0) r = 9'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [3:0] clamp4(logic [3:0] v, logic [3:0] hi);
    logic [3:0] r;
    if (v == 4'd0) r = 4'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

  function automatic logic [2:0] clamp3(logic [2:0] v, logic [2:0] hi);
    logic [2:0] r;
    if (v == 3'd0) r = 3'd1;
    else if (v > hi) r = hi;
    else r = v;
    return r;
  endfunction

endpackage

// ===== rtl/mfsc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsc channel interfaces
// valid/ready channels for input items, results and register writes
// ----------------------------------------------------------------------------
interface mfsc_in_if;
  import mfsc_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfsc_out_if;
  import mfsc_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface mfsc_cfg_if;
  import mfsc_pkg::*;
  logic      valid;
  logic      ready;
  cfg_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/multi_filter_strided_convolution_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_filter_strided_convolution_core
// valid-mode strided 2d convolution with a bank of filters, one shared mac
// ----------------------------------------------------------------------------
// Pixel elements arrive in raster order with channels interleaved and go to a
// line store of the last eight rows; weight items load the filter store. An
// element that causes no window, and any weight item, leaves the block ready
// for the next item. When the last channel of a pixel completes a window on
// the stride grid the block runs every filter in use through one shared
// multiply-accumulate unit, one product per cycle; input ready stays low
// meanwhile. Results leave through an output register, so a waiting result
// does not hold back the next input. After reset a clearing pass zeroes all
// 2048 entries of the filter store, during which no item is taken; register
// writes are taken at all times, and writes to a known register restart the
// image.
// ----------------------------------------------------------------------------
module multi_filter_strided_convolution_core (
  input  logic clk_i,
  input  logic rst_ni,
  mfsc_in_if.sink    in_i,
  mfsc_out_if.source out_o,
  mfsc_cfg_if.sink   cfg_i
);
  import mfsc_pkg::*;

  // handshakes
  logic in_acc, pix_acc, wgt_acc, cfg_acc, cfg_hit, out_free;

  // configuration registers, raw
  logic [8:0] width_q, height_q;
  logic [3:0] ksize_q, step_q, nfilt_q;
  logic [2:0] nchan_q;

  // clamped values
  logic [8:0] w_eff, h_eff;
  logic [3:0] k_eff, s_eff, nf_eff, k_m1;
  logic [2:0] nc_eff;

  // raster position and stride phase
  logic [7:0] row_q, row_d, col_q, col_d, orow_q, orow_d, ocol_q, ocol_d;
  logic [1:0] ch_q, ch_d;
  logic [2:0] rph_q, rph_d, cph_q, cph_d;
  logic       ch_last, row_in, col_in, fire;

  // window being worked on
  logic [7:0] top_q, left_q, res_row_q, res_col_q;
  logic [2:0] f_q, r_q, c_q;
  logic [1:0] q_q;
  logic       last_q, last_c, last_r, last_f;

  state_e     state_q, state_d;
  logic [WGT_AW-1:0] clr_q;

  mac_ctrl_t  iss, ctl1_q;
  logic signed [SUM_W-1:0] acc;
  logic       mac_done;

  // memories
  logic                  wgt_we;
  logic [WGT_AW-1:0]     wgt_waddr, wgt_raddr;
  logic [DATA_W-1:0]     wgt_wdata, wgt_rdata;
  logic [LINE_AW-1:0]    line_waddr, line_raddr;
  logic [DATA_W-1:0]     line_rdata;

  logic       out_valid_q;
  out_item_t  out_item_q;

  assign in_acc   = in_i.valid & in_i.ready;
  assign pix_acc  = in_acc & (in_i.data.opcode == OP_PIXEL);
  assign wgt_acc  = in_acc & (in_i.data.opcode == OP_WEIGHT);
  assign cfg_acc  = cfg_i.valid & cfg_i.ready;
  assign out_free = ~out_valid_q | out_o.ready;

  // only writes to a known register restart the image
  always_comb begin
    cfg_hit = 1'b0;
    case (cfg_i.data.index)
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_KERNEL_SIZE,
      REG_STEP_SIZE, REG_FILTER_COUNT, REG_CHANNEL_COUNT: cfg_hit = cfg_acc;
      default: cfg_hit = 1'b0;
    endcase
  end

  assign w_eff  = clamp9(width_q, 9'(MAX_WIDTH));
  assign h_eff  = clamp9(height_q, 9'd256);
  assign k_eff  = clamp4(ksize_q, 4'(MAX_KERNEL));
  assign s_eff  = clamp4(step_q, 4'd8);
  assign nf_eff = clamp4(nfilt_q, 4'(MAX_FILTERS));
  assign nc_eff = clamp3(nchan_q, 3'(MAX_CHANNELS));
  assign k_m1   = k_eff - 4'd1;

  // window test: corner on the grid when both stride phases are zero
  assign ch_last = ({1'b0, ch_q} + 3'd1) >= nc_eff;
  assign row_in  = row_q >= {4'd0, k_m1};
  assign col_in  = col_q >= {4'd0, k_m1};
  assign fire    = ch_last & row_in & col_in & (rph_q == 3'd0) & (cph_q == 3'd0);

  // raster advance with stride phase and output map position
  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    ch_d   = ch_q + 2'd1;
    rph_d  = rph_q;
    cph_d  = cph_q;
    orow_d = orow_q;
    ocol_d = ocol_q;
    if (ch_last) begin
      ch_d = 2'd0;
      if (({1'b0, col_q} + 9'd1) >= w_eff) begin
        col_d  = 8'd0;
        cph_d  = 3'd0;
        ocol_d = 8'd0;
        if (({1'b0, row_q} + 9'd1) >= h_eff) begin
          row_d  = 8'd0;
          rph_d  = 3'd0;
          orow_d = 8'd0;
        end else begin
          row_d = row_q + 8'd1;
          if (row_in) begin
            if (({1'b0, rph_q} + 4'd1) == s_eff) begin
              rph_d  = 3'd0;
              orow_d = orow_q + 8'd1;
            end else begin
              rph_d = rph_q + 3'd1;
            end
          end
        end
      end else begin
        col_d = col_q + 8'd1;
        if (col_in) begin
          if (({1'b0, cph_q} + 4'd1) == s_eff) begin
            cph_d  = 3'd0;
            ocol_d = ocol_q + 8'd1;
          end else begin
            cph_d = cph_q + 3'd1;
          end
        end
      end
    end
  end

  // loop ends of the window sweep
  assign last_q = ({1'b0, q_q} + 3'd1) == nc_eff;
  assign last_c = ({1'b0, c_q} + 4'd1) == k_eff;
  assign last_r = ({1'b0, r_q} + 4'd1) == k_eff;
  assign last_f = ({1'b0, f_q} + 4'd1) == nf_eff;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: if (clr_q == '1) state_d = ST_IDLE;
      ST_IDLE:  if (pix_acc && fire) state_d = ST_RUN;
      ST_RUN:   if (last_q && last_c && last_r) state_d = ST_WAIT;
      ST_WAIT:  if (mac_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = last_f ? ST_IDLE : ST_RUN;
      end
      default:  state_d = ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_i.ready  = (state_q == ST_IDLE);
    cfg_i.ready = 1'b1;
    iss.valid   = (state_q == ST_RUN);
    iss.first   = (r_q == 3'd0) && (c_q == 3'd0) && (q_q == 2'd0);
    iss.last    = (state_q == ST_RUN) && last_q && last_c && last_r;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  // filter store: zeroed by the clearing pass, then loaded by weight items
  always_comb begin
    wgt_we    = wgt_acc;
    wgt_waddr = {in_i.data.weight_filter, in_i.data.weight_row,
                 in_i.data.weight_col, in_i.data.weight_channel};
    wgt_wdata = in_i.data.weight_value;
    if (state_q == ST_CLEAR) begin
      wgt_we    = 1'b1;
      wgt_waddr = clr_q;
      wgt_wdata = '0;
    end
  end

  assign wgt_raddr  = {f_q, r_q, c_q, q_q};
  assign line_waddr = {row_q[KER_W-1:0], col_q, ch_q};
  // line store row wraps modulo the kernel limit
  assign line_raddr = {top_q[KER_W-1:0] + r_q, left_q + {5'd0, c_q}, q_q};

  mfsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (WGT_DEPTH)
  ) u_wgt_ram (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_waddr),
    .wdata_i (wgt_wdata),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  mfsc_ram #(
    .WIDTH (DATA_W),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (pix_acc),
    .waddr_i (line_waddr),
    .wdata_i (in_i.data.pixel_value),
    .raddr_i (line_raddr),
    .rdata_o (line_rdata)
  );

  mfsc_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctl1_q),
    .px_i   (line_rdata),
    .wt_i   (wgt_rdata),
    .acc_o  (acc),
    .done_o (mac_done)
  );

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      width_q     <= 9'd32;
      height_q    <= 9'd32;
      ksize_q     <= 4'd5;
      step_q      <= 4'd1;
      nfilt_q     <= 4'd8;
      nchan_q     <= 3'd3;
      row_q       <= '0;
      col_q       <= '0;
      ch_q        <= '0;
      rph_q       <= '0;
      cph_q       <= '0;
      orow_q      <= '0;
      ocol_q      <= '0;
      f_q         <= '0;
      r_q         <= '0;
      c_q         <= '0;
      q_q         <= '0;
      ctl1_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ctl1_q  <= iss;

      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end

      if (cfg_acc) begin
        case (cfg_i.data.index)
          REG_IMAGE_WIDTH:   width_q  <= cfg_i.data.value;
          REG_IMAGE_HEIGHT:  height_q <= cfg_i.data.value;
          REG_KERNEL_SIZE:   ksize_q  <= cfg_i.data.value[3:0];
          REG_STEP_SIZE:     step_q   <= cfg_i.data.value[3:0];
          REG_FILTER_COUNT:  nfilt_q  <= cfg_i.data.value[3:0];
          REG_CHANNEL_COUNT: nchan_q  <= cfg_i.data.value[2:0];
          default: ;
        endcase
      end

      if (cfg_hit) begin
        row_q  <= '0;
        col_q  <= '0;
        ch_q   <= '0;
        rph_q  <= '0;
        cph_q  <= '0;
        orow_q <= '0;
        ocol_q <= '0;
      end else if (pix_acc) begin
        row_q  <= row_d;
        col_q  <= col_d;
        ch_q   <= ch_d;
        rph_q  <= rph_d;
        cph_q  <= cph_d;
        orow_q <= orow_d;
        ocol_q <= ocol_d;
      end

      if (pix_acc && fire) begin
        f_q <= '0;
        r_q <= '0;
        c_q <= '0;
        q_q <= '0;
      end else if (state_q == ST_RUN) begin
        // channel innermost, then column, then row; all wrap at the end
        if (last_q) begin
          q_q <= '0;
          if (last_c) begin
            c_q <= '0;
            r_q <= last_r ? 3'd0 : r_q + 3'd1;
          end else begin
            c_q <= c_q + 3'd1;
          end
        end else begin
          q_q <= q_q + 2'd1;
        end
      end else if (state_q == ST_EMIT && out_free && !last_f) begin
        f_q <= f_q + 3'd1;
      end

      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // window origin and result payload
  always_ff @(posedge clk_i) begin
    if (pix_acc && fire) begin
      top_q     <= row_q - {4'd0, k_m1};
      left_q    <= col_q - {4'd0, k_m1};
      res_row_q <= orow_q;
      res_col_q <= ocol_q;
    end
    if (state_q == ST_EMIT && out_free) begin
      out_item_q.out_row       <= res_row_q;
      out_item_q.out_col       <= res_col_q;
      out_item_q.filter_index  <= f_q;
      out_item_q.dot_sum       <= acc;
      out_item_q.last_of_pixel <= last_f;
    end
  end

endmodule

// ===== rtl/mfsc_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module mfsc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/mfsc_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsc_mac
// shared multiply-accumulate unit, product stage then accumulate stage
// ----------------------------------------------------------------------------
module mfsc_mac (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  mfsc_pkg::mac_ctrl_t               ctrl_i,
  input  logic [mfsc_pkg::DATA_W-1:0]       px_i,
  input  logic [mfsc_pkg::DATA_W-1:0]       wt_i,
  output logic signed [mfsc_pkg::SUM_W-1:0] acc_o,
  output logic                              done_o
);
  import mfsc_pkg::*;

  logic signed [PROD_W-1:0] prod_d, prod_q;
  mac_ctrl_t                ctl_q;
  logic signed [SUM_W-1:0]  acc_d, acc_q;
  logic                     done_q;

  // unsigned pixel times signed weight
  assign prod_d = $signed({1'b0, px_i}) * $signed(wt_i);

  always_comb begin
    acc_d = ctl_q.first ? {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q}
                        : acc_q + {{(SUM_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q  <= '0;
      done_q <= 1'b0;
    end else begin
      ctl_q  <= ctrl_i;
      done_q <= ctl_q.valid & ctl_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    if (ctl_q.valid) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o  = acc_q;
  assign done_o = done_q;

endmodule

// ===== tb/sv/mfsc_tb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfsc testbench channel notes
// the channel interfaces themselves come with the rtl; this file holds the
// shared helper type of the test
// ----------------------------------------------------------------------------
package mfsc_test_pkg;
  import mfsc_pkg::*;

  // one row of the directed stimulus table
  typedef struct {
    logic      is_cfg;
    cfg_item_t cfg;
    in_item_t  item;
    logic      has_fixed;
    logic signed [SUM_W-1:0] fixed_sum;
  } stim_row_t;
endpackage

// ===== tb/sv/multi_filter_strided_convolution_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_filter_strided_convolution_core_test
// self-checking test of the strided convolution core
// ----------------------------------------------------------------------------
// A directed table exercises register clamping, weight address handling,
// kernel larger than image and a few fixed sums; random phases then load
// random weights and stream pixels at varied settings. Every result is
// compared with an in-bench model of the convolution. The sender bursts, the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module multi_filter_strided_convolution_core_test;
  import mfsc_pkg::*;
  import mfsc_test_pkg::*;

  localparam int LIMIT = 3000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #4 clk_i = ~clk_i;

  mfsc_in_if  in_ch ();
  mfsc_out_if out_ch ();
  mfsc_cfg_if cfg_ch ();

  multi_filter_strided_convolution_core u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source),
    .cfg_i (cfg_ch.sink)
  );

  // model state
  logic [8:0]  reg_val [6];
  logic [15:0] line_mem [LINE_DEPTH];
  logic [15:0] wgt_mem [WGT_DEPTH];
  int unsigned row_pos, col_pos, ch_pos;

  out_item_t expected_q [$];
  int errors = 0;
  int cycles = 0;

  function automatic int unsigned clampu(int unsigned v, int unsigned hi);
    if (v < 1) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic int unsigned eff(int i);
    case (i)
      REG_IMAGE_WIDTH:   return clampu(reg_val[i], MAX_WIDTH);
      REG_IMAGE_HEIGHT:  return clampu(reg_val[i], 256);
      REG_KERNEL_SIZE:   return clampu(reg_val[i] & 4'hF, MAX_KERNEL);
      REG_STEP_SIZE:     return clampu(reg_val[i] & 4'hF, 8);
      REG_FILTER_COUNT:  return clampu(reg_val[i] & 4'hF, MAX_FILTERS);
      default:           return clampu(reg_val[i] & 3'h7, MAX_CHANNELS);
    endcase
  endfunction

  function automatic int unsigned line_at(int unsigned r, int unsigned c, int unsigned q);
    return (((r % MAX_KERNEL) * MAX_WIDTH) + c) * MAX_CHANNELS + q;
  endfunction

  function automatic int unsigned wgt_at(int unsigned f, int unsigned r, int unsigned c,
                                         int unsigned q);
    return ((f * MAX_KERNEL + r) * MAX_KERNEL + c) * MAX_CHANNELS + q;
  endfunction

  task automatic model_cfg(cfg_item_t c);
    if (c.index <= REG_CHANNEL_COUNT) begin
      reg_val[c.index] = c.value;
      row_pos = 0; col_pos = 0; ch_pos = 0;
    end
  endtask

  // convolution predictor: queues the sums the item causes
  task automatic predict_window(in_item_t it);
    int unsigned w, h, k, s, nf, nc, top, left;
    logic signed [SUM_W-1:0] acc;
    out_item_t o;
    w = eff(REG_IMAGE_WIDTH); h = eff(REG_IMAGE_HEIGHT); k = eff(REG_KERNEL_SIZE);
    s = eff(REG_STEP_SIZE); nf = eff(REG_FILTER_COUNT); nc = eff(REG_CHANNEL_COUNT);
    if (it.opcode == OP_WEIGHT) begin
      wgt_mem[wgt_at(it.weight_filter, it.weight_row, it.weight_col, it.weight_channel)] =
        it.weight_value;
      return;
    end
    line_mem[line_at(row_pos, col_pos, ch_pos)] = it.pixel_value;
    if (ch_pos + 1 >= nc && row_pos + 1 >= k && col_pos + 1 >= k &&
        (row_pos + 1 - k) % s == 0 && (col_pos + 1 - k) % s == 0) begin
      top = row_pos + 1 - k; left = col_pos + 1 - k;
      for (int f = 0; f < nf; f++) begin
        acc = '0;
        for (int r = 0; r < k; r++)
          for (int c = 0; c < k; c++)
            for (int q = 0; q < nc; q++)
              acc += $signed({1'b0, line_mem[line_at(top + r, left + c, q)]}) *
                     $signed(wgt_mem[wgt_at(f, r, c, q)]);
        o.out_row = 8'(top / s); o.out_col = 8'(left / s);
        o.filter_index = 3'(f); o.dot_sum = acc;
        o.last_of_pixel = (f + 1 == nf);
        expected_q = {expected_q, o};
      end
    end
    ch_pos++;
    if (ch_pos >= nc) begin
      ch_pos = 0; col_pos++;
      if (col_pos >= w) begin
        col_pos = 0; row_pos++;
        if (row_pos >= h) row_pos = 0;
      end
    end
  endtask

  // ---------------- drivers ----------------
  initial begin
    in_ch.valid = 1'b0; in_ch.data = '0;
    cfg_ch.valid = 1'b0; cfg_ch.data = '0;
    out_ch.ready = 1'b0;
  end

  // receiver stall pattern: phases of always-ready and random stalls
  int unsigned stall_mode = 0;
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
    case (stall_mode)
      0:       out_ch.ready <= 1'b1;
      1:       out_ch.ready <= ($urandom_range(0, 3) != 0);
      default: out_ch.ready <= ($urandom_range(0, 7) == 0);
    endcase
  end

  // result checking
  always @(posedge clk_i) begin
    out_item_t exp_item;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %p", out_ch.data);
      end else begin
        exp_item = expected_q.pop_front();
        if (exp_item !== out_ch.data) begin
          errors++;
          if (errors <= 10) $display("mismatch exp %p got %p", exp_item, out_ch.data);
        end
      end
    end
  end

  // timeout
  always @(posedge clk_i) begin
    if (cycles > LIMIT) begin
      $display("[multi_filter_strided_convolution_core] ERROR");
      $finish;
    end
  end

  int unsigned burst_left = 0;

  // send one item, honouring the burst/gap pattern; valid stays up between
  // transfers of a burst
  task automatic send_item(in_item_t it);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 1) ? 0 : $urandom_range(1, 12);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    predict_window(it);
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  // drain everything, then let the block settle before a register write
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [8:0] val);
    cfg_item_t c;
    c.index = idx; c.value = val;
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= c;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    @(posedge clk_i);
    model_cfg(c);
  endtask

  function automatic in_item_t pixel(logic [15:0] v);
    in_item_t it = '0;
    it.opcode = OP_PIXEL; it.pixel_value = v;
    it.weight_value = 16'($urandom); it.weight_filter = 3'($urandom);
    return it;
  endfunction

  function automatic in_item_t weight(int f, int r, int c, int q, logic [15:0] v);
    in_item_t it = '0;
    it.opcode = OP_WEIGHT; it.weight_value = v; it.pixel_value = 16'($urandom);
    it.weight_filter = 3'(f); it.weight_row = 3'(r);
    it.weight_col = 3'(c); it.weight_channel = 2'(q);
    return it;
  endfunction

  function automatic stim_row_t cfg_row(cfg_reg_e idx, logic [8:0] v);
    stim_row_t s = '{default: '0};
    s.is_cfg = 1'b1; s.cfg.index = idx; s.cfg.value = v;
    return s;
  endfunction

  function automatic stim_row_t item_row(in_item_t it, logic has_fixed,
                                         logic signed [SUM_W-1:0] fs);
    stim_row_t s = '{default: '0};
    s.item = it; s.has_fixed = has_fixed; s.fixed_sum = fs;
    return s;
  endfunction

  stim_row_t table_rows [$];

  task automatic add_row(stim_row_t s);
    table_rows = {table_rows, s};
  endtask

  // random image phase with random content
  task automatic random_phase(int unsigned n_items);
    int unsigned w, h, k, nc, nf, cnt;
    w  = $urandom_range(1, 12);
    h  = $urandom_range(1, 10);
    k  = $urandom_range(1, 4);
    nc = $urandom_range(1, 4);
    nf = $urandom_range(1, 8);
    if ($urandom_range(0, 9) == 0) begin w = MAX_WIDTH; h = 2; k = 1; nf = 1; nc = 1; end
    if ($urandom_range(0, 9) == 0) begin k = 8; w = 9; h = 9; end
    write_reg(REG_IMAGE_WIDTH, 9'(w));
    write_reg(REG_IMAGE_HEIGHT, 9'(h));
    write_reg(REG_KERNEL_SIZE, 9'(k));
    write_reg(REG_STEP_SIZE, 9'($urandom_range(0, 9)));
    write_reg(REG_FILTER_COUNT, 9'(nf));
    write_reg(REG_CHANNEL_COUNT, 9'(nc));
    for (int i = 0; i < 8; i++) begin
      cnt = $urandom_range(0, 3) == 0 ? 16'h8000 : $urandom;
      send_item(weight($urandom_range(0, 7), $urandom_range(0, k - 1),
                       $urandom_range(0, k - 1), $urandom_range(0, 3), 16'(cnt)));
    end
    for (int i = 0; i < n_items; i++) begin
      if ($urandom_range(0, 15) == 0)
        send_item(weight($urandom, $urandom, $urandom, $urandom, 16'($urandom)));
      else
        send_item(pixel($urandom_range(0, 3) == 0 ? 16'hFFFF : 16'($urandom)));
    end
  endtask

  initial begin
    stim_row_t row;
    reg_val[REG_IMAGE_WIDTH] = 32; reg_val[REG_IMAGE_HEIGHT] = 32;
    reg_val[REG_KERNEL_SIZE] = 5;  reg_val[REG_STEP_SIZE] = 1;
    reg_val[REG_FILTER_COUNT] = 8; reg_val[REG_CHANNEL_COUNT] = 3;
    foreach (line_mem[i]) line_mem[i] = '0;
    foreach (wgt_mem[i]) wgt_mem[i] = '0;
    row_pos = 0; col_pos = 0; ch_pos = 0;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // 1x1 kernel, one channel, one filter: sum is pixel times weight
    add_row(cfg_row(REG_KERNEL_SIZE, 9'd0));      // zero acts as one
    add_row(cfg_row(REG_CHANNEL_COUNT, 9'd1));
    add_row(cfg_row(REG_FILTER_COUNT, 9'd1));
    add_row(cfg_row(REG_STEP_SIZE, 9'd15));        // clamps to eight
    add_row(cfg_row(REG_IMAGE_WIDTH, 9'd4));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 9'd511));
    // zero weights after reset
    add_row(item_row(pixel(16'hFFFF), 1'b1, 40'sd0));
    add_row(item_row(weight(0, 0, 0, 0, 16'h8000), 1'b0, '0));
    // corner is off the stride grid for the next pixels
    add_row(item_row(pixel(16'hFFFF), 1'b0, '0));
    add_row(cfg_row(REG_IMAGE_WIDTH, 9'd4));       // restart image
    add_row(item_row(pixel(16'hFFFF), 1'b1, -40'sd2147450880));
    add_row(item_row(weight(0, 0, 0, 0, 16'h7FFF), 1'b0, '0));
    add_row(item_row(weight(7, 7, 7, 3, 16'h1234), 1'b0, '0));
    add_row(cfg_row(REG_IMAGE_WIDTH, 9'd0));
    add_row(item_row(pixel(16'hFFFF), 1'b1, 40'sd2147385345));
    // second row of a one-pixel-wide image is off the stride grid
    add_row(item_row(pixel(16'h0000), 1'b0, '0));
    // kernel larger than image gives nothing
    add_row(cfg_row(REG_KERNEL_SIZE, 9'd15));
    add_row(cfg_row(REG_IMAGE_WIDTH, 9'd3));
    add_row(cfg_row(REG_IMAGE_HEIGHT, 9'd3));
    for (int i = 0; i < 6; i++)
      add_row(item_row(pixel(16'($urandom)), 1'b0, '0));

    foreach (table_rows[i]) begin
      row = table_rows[i];
      if (row.is_cfg) begin
        drain();
        write_reg(cfg_reg_e'(row.cfg.index), row.cfg.value);
      end else begin
        send_item(row.item);
        // fixed sums cross-check the predictor itself
        if (row.has_fixed && expected_q.size() != 0 &&
            expected_q[$].dot_sum !== row.fixed_sum) begin
          errors++;
          if (errors <= 10)
            $display("table row %0d exp %0d model %0d", i, row.fixed_sum,
                     expected_q[$].dot_sum);
        end
      end
    end

    // random phases, each after a full pause until all results are back
    for (int p = 0; p < 10; p++) begin
      drain();
      random_phase($urandom_range(30, 70));
    end

    drain();
    repeat (2200) @(posedge clk_i);
    if (errors == 0 && expected_q.size() == 0) begin
      $display("[multi_filter_strided_convolution_core] OK");
    end else begin
      $display("[multi_filter_strided_convolution_core] ERROR");
    end
    $finish;
  end

endmodule
